// File: sv/sccb_pkg.sv
// shared constants, types and helpers for the sccb master controller
`default_nettype none

package sccb_pkg;

    typedef logic [3:0]  t_phase;
    typedef logic [2:0]  t_seg;
    typedef logic [11:0] t_delay;
    typedef logic [3:0]  t_units;

    // request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // register index codes (paddr bit 2)
    localparam logic REG_TICKS_PER_UNIT = 1'b0;
    localparam logic REG_SLAVE_ADDRESS  = 1'b1;

    localparam int   APB_ADDR_W = 3;
    localparam int   APB_DATA_W = 32;

    localparam logic [7:0] TICKS_PER_UNIT_RST = 8'd1;
    localparam logic [6:0] SLAVE_ADDRESS_RST  = 7'd33;

    // bus sequencer phases
    localparam t_phase P_IDLE     = 4'd0;
    localparam t_phase P_STOP_A   = 4'd1;
    localparam t_phase P_STOP_B   = 4'd2;
    localparam t_phase P_STOP_C   = 4'd3;
    localparam t_phase P_DONE     = 4'd4;
    localparam t_phase P_START_A  = 4'd5;
    localparam t_phase P_START_B  = 4'd6;
    localparam t_phase P_START_C  = 4'd7;
    localparam t_phase P_BIT_HI   = 4'd8;
    localparam t_phase P_BIT_LO   = 4'd9;
    localparam t_phase P_ACK_HI   = 4'd10;
    localparam t_phase P_ACK_WAIT = 4'd11;
    localparam t_phase P_ACK_END  = 4'd12;
    localparam t_phase P_RX_HI    = 4'd13;
    localparam t_phase P_RX_LO    = 4'd14;
    localparam t_phase P_NA_HI    = 4'd15;

    // transaction segments
    localparam t_seg SEG_LEAD_STOP = 3'd0;
    localparam t_seg SEG_ADDR_WR   = 3'd1;
    localparam t_seg SEG_REG       = 3'd2;
    localparam t_seg SEG_DATA      = 3'd3;
    localparam t_seg SEG_ADDR_RD   = 3'd4;
    localparam t_seg SEG_RX        = 3'd5;
    localparam t_seg SEG_FINAL     = 3'd6;

    // delay lengths in units
    localparam t_units U_3  = 4'd3;
    localparam t_units U_5  = 4'd5;
    localparam t_units U_8  = 4'd8;
    localparam t_units U_10 = 4'd10;
    localparam t_units U_13 = 4'd13;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // ticks to wait after an action, minus one
    function automatic t_delay delay_load(input t_units units, input logic [7:0] tpu);
        logic [7:0]  t;
        logic [11:0] p;
        t = (tpu == 8'd0) ? 8'd1 : tpu;
        p = 12'(units) * 12'(t);
        return p - 12'd1;
    endfunction

endpackage

`default_nettype wire

// File: sv/sccb_master_controller_core.sv
// sccb master controller: tick-driven bus sequencer with apb configuration
// the result of a tick item is registered and presented in the cycle after the item is accepted
// throughput: one tick item per cycle unless a held result is stalled; the output register lets a new item in
//   while the previous result is taken in the same cycle
// the whole sequencer update is one pass of logic between state and result registers
// reset: sequencer idle, scl and sda high and driven, ticks_per_unit 1, slave_address 33
`default_nettype none

module sccb_master_controller_core (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [sccb_pkg::APB_ADDR_W-1:0] paddr,
    input  wire [sccb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sccb_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire [1:0]                      i_req_type,
    input  wire [7:0]                      i_dev_reg,
    input  wire [7:0]                      i_write_data,
    input  wire                            i_sda_in,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic                           o_scl_level,
    output logic                           o_sda_level,
    output logic                           o_sda_drive,
    output logic                           o_busy_res,
    output logic                           o_done_res,
    output logic [7:0]                     o_read_result
);
    import sccb_pkg::*;

    logic [7:0] r_tpu;
    logic [6:0] r_slave;

    t_phase     r_phase, n_phase;
    t_seg       r_seg, n_seg;
    t_delay     r_delay, n_delay;
    logic [3:0] r_bits, n_bits;
    logic [7:0] r_tx, n_tx;
    logic [7:0] r_rx, n_rx;
    logic [7:0] r_held_reg, n_held_reg;
    logic [7:0] r_held_data, n_held_data;
    logic       r_is_read, n_is_read;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic       r_drive, n_drive;
    logic [7:0] r_last, n_last;
    logic       n_done;

    logic       r_out_valid;
    logic       r_o_scl, r_o_sda, r_o_drive, r_o_busy, r_o_done;
    logic [7:0] r_o_read;

    logic       in_acc;
    logic       cfg_wr;
    logic [3:0] bits_inc;
    logic [7:0] tx_sh;

    assign pready     = 1'b1;
    assign cfg_wr     = psel & penable & pwrite & pready;
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign bits_inc   = r_bits + 4'd1;
    assign tx_sh      = {r_tx[6:0], 1'b0};

    always_comb begin
        unique case (paddr[2])
            REG_TICKS_PER_UNIT: prdata = {24'd0, r_tpu};
            REG_SLAVE_ADDRESS:  prdata = {25'd0, r_slave};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu   <= TICKS_PER_UNIT_RST;
            r_slave <= SLAVE_ADDRESS_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_TICKS_PER_UNIT) begin
                r_tpu <= pwdata[7:0];
            end else begin
                r_slave <= pwdata[6:0];
            end
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_seg       = r_seg;
        n_delay     = r_delay;
        n_bits      = r_bits;
        n_tx        = r_tx;
        n_rx        = r_rx;
        n_held_reg  = r_held_reg;
        n_held_data = r_held_data;
        n_is_read   = r_is_read;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_drive     = r_drive;
        n_last      = r_last;
        n_done      = 1'b0;

        priority if (r_phase == P_IDLE) begin
            if (i_req_type == REQ_WRITE || i_req_type == REQ_READ) begin
                n_held_reg  = i_dev_reg;
                n_held_data = i_write_data;
                n_is_read   = (i_req_type == REQ_READ);
                n_seg       = SEG_LEAD_STOP;
                n_delay     = delay_load(U_5, r_tpu);
                n_phase     = P_STOP_A;
            end
        end else if (r_delay != '0) begin
            n_delay = r_delay - 12'd1;
        end else begin
            unique case (r_phase)
                P_STOP_A: begin
                    n_scl   = 1'b1;
                    n_delay = delay_load(U_5, r_tpu);
                    n_phase = P_STOP_B;
                end
                P_STOP_B: begin
                    n_sda   = 1'b0;
                    n_drive = 1'b1;
                    n_delay = delay_load(U_5, r_tpu);
                    n_phase = P_STOP_C;
                end
                P_STOP_C: begin
                    n_sda = 1'b1;
                    priority if (r_seg == SEG_FINAL) begin
                        n_delay = delay_load(U_3, r_tpu);
                        n_phase = P_DONE;
                    end else if (r_seg == SEG_LEAD_STOP) begin
                        n_seg   = SEG_ADDR_WR;
                        n_delay = delay_load(r_is_read ? U_8 : U_13, r_tpu);
                        n_phase = P_START_A;
                    end else if (r_seg == SEG_DATA) begin
                        n_seg   = SEG_ADDR_RD;
                        n_delay = delay_load(U_8, r_tpu);
                        n_phase = P_START_A;
                    end else begin
                        n_phase = P_IDLE;
                        n_delay = '0;
                    end
                end
                P_DONE: begin
                    if (r_is_read) begin
                        n_last = r_rx;
                    end
                    n_phase = P_IDLE;
                    n_delay = '0;
                    n_done  = 1'b1;
                end
                P_START_A: begin
                    n_sda   = 1'b1;
                    n_scl   = 1'b1;
                    n_drive = 1'b1;
                    n_delay = delay_load(U_5, r_tpu);
                    n_phase = P_START_B;
                end
                P_START_B: begin
                    n_sda   = 1'b0;
                    n_delay = delay_load(U_5, r_tpu);
                    n_phase = P_START_C;
                end
                P_START_C: begin
                    n_scl = 1'b0;
                    priority if (r_seg == SEG_ADDR_WR || r_seg == SEG_ADDR_RD) begin
                        n_tx    = {r_slave, r_seg == SEG_ADDR_RD};
                        n_bits  = '0;
                        n_drive = 1'b1;
                        n_sda   = r_slave[6];
                        n_delay = delay_load(U_5, r_tpu);
                        n_phase = P_BIT_HI;
                    end else begin
                        n_phase = P_IDLE;
                        n_delay = '0;
                    end
                end
                P_BIT_HI: begin
                    n_scl   = 1'b1;
                    n_delay = delay_load(U_5, r_tpu);
                    n_phase = P_BIT_LO;
                end
                P_BIT_LO: begin
                    n_scl  = 1'b0;
                    n_tx   = tx_sh;
                    n_bits = bits_inc;
                    if (bits_inc < BITS_PER_BYTE) begin
                        n_sda   = tx_sh[7];
                        n_delay = delay_load(U_5, r_tpu);
                        n_phase = P_BIT_HI;
                    end else begin
                        n_drive = 1'b0;
                        n_delay = delay_load(U_3, r_tpu);
                        n_phase = P_ACK_HI;
                    end
                end
                P_ACK_HI: begin
                    n_scl   = 1'b1;
                    n_phase = P_ACK_WAIT;
                    n_delay = '0;
                end
                P_ACK_WAIT: begin
                    if (!i_sda_in) begin
                        n_delay = delay_load(U_5, r_tpu);
                        n_phase = P_ACK_END;
                    end
                end
                P_ACK_END: begin
                    n_scl   = 1'b0;
                    n_drive = 1'b1;
                    priority if (r_seg == SEG_ADDR_WR) begin
                        n_seg   = SEG_REG;
                        n_tx    = r_held_reg;
                        n_bits  = '0;
                        n_sda   = r_held_reg[7];
                        n_delay = delay_load(U_5, r_tpu);
                        n_phase = P_BIT_HI;
                    end else if (r_seg == SEG_REG) begin
                        n_seg   = SEG_DATA;
                        n_delay = delay_load(U_5, r_tpu);
                        if (!r_is_read) begin
                            n_tx    = r_held_data;
                            n_bits  = '0;
                            n_sda   = r_held_data[7];
                            n_phase = P_BIT_HI;
                        end else begin
                            n_phase = P_STOP_A;
                        end
                    end else if (r_seg == SEG_DATA) begin
                        n_seg   = SEG_FINAL;
                        n_delay = delay_load(U_5, r_tpu);
                        n_phase = P_STOP_A;
                    end else if (r_seg == SEG_ADDR_RD) begin
                        n_seg   = SEG_RX;
                        n_drive = 1'b0;
                        n_rx    = '0;
                        n_bits  = '0;
                        n_delay = delay_load(U_5, r_tpu);
                        n_phase = P_RX_HI;
                    end else begin
                        n_phase = P_IDLE;
                        n_delay = '0;
                    end
                end
                P_RX_HI: begin
                    n_scl   = 1'b1;
                    n_rx    = {r_rx[6:0], i_sda_in};
                    n_delay = delay_load(U_5, r_tpu);
                    n_phase = P_RX_LO;
                end
                P_RX_LO: begin
                    n_scl  = 1'b0;
                    n_bits = bits_inc;
                    n_delay = delay_load(U_5, r_tpu);
                    if (bits_inc < BITS_PER_BYTE) begin
                        n_phase = P_RX_HI;
                    end else begin
                        n_drive = 1'b1;
                        n_sda   = 1'b1;
                        n_phase = P_NA_HI;
                    end
                end
                P_NA_HI: begin
                    n_scl   = 1'b1;
                    n_seg   = SEG_FINAL;
                    n_delay = delay_load(U_10, r_tpu);
                    n_phase = P_STOP_A;
                end
                default: begin
                    n_phase = P_IDLE;
                    n_delay = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= P_IDLE;
            r_seg       <= SEG_LEAD_STOP;
            r_delay     <= '0;
            r_bits      <= '0;
            r_tx        <= '0;
            r_rx        <= '0;
            r_held_reg  <= '0;
            r_held_data <= '0;
            r_is_read   <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_drive     <= 1'b1;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase     <= n_phase;
                r_seg       <= n_seg;
                r_delay     <= n_delay;
                r_bits      <= n_bits;
                r_tx        <= n_tx;
                r_rx        <= n_rx;
                r_held_reg  <= n_held_reg;
                r_held_data <= n_held_data;
                r_is_read   <= n_is_read;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_drive     <= n_drive;
                r_last      <= n_last;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_o_scl   <= n_scl;
            r_o_sda   <= n_drive & n_sda;
            r_o_drive <= n_drive;
            r_o_busy  <= (n_phase != P_IDLE);
            r_o_done  <= n_done;
            r_o_read  <= n_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_scl_level   = r_o_scl;
    assign o_sda_level   = r_o_sda;
    assign o_sda_drive   = r_o_drive;
    assign o_busy_res    = r_o_busy;
    assign o_done_res    = r_o_done;
    assign o_read_result = r_o_read;

    a_idle_no_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == P_IDLE |-> r_delay == '0)
        else $error("delay counter running while idle");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done reported while still busy");

    a_released_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_sda_drive |-> !o_sda_level)
        else $error("sda level set while released");

    a_req_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_phase == P_IDLE && (i_req_type == REQ_WRITE || i_req_type == REQ_READ)
        |=> r_phase == P_STOP_A && r_seg == SEG_LEAD_STOP)
        else $error("request did not start a transaction");

    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg <= SEG_FINAL)
        else $error("segment out of range");

endmodule

`default_nettype wire

// File: tb/sccb_tick_checker.sv
`timescale 1ns / 100ps
// checker for the sccb master: predicts the lines, busy, done and read result of every tick item and compares them

module sccb_tick_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_psel,
    input  wire                             i_penable,
    input  wire                             i_pwrite,
    input  wire [sccb_pkg::APB_ADDR_W-1:0]  i_paddr,
    input  wire [sccb_pkg::APB_DATA_W-1:0]  i_pwdata,
    input  wire [sccb_pkg::APB_DATA_W-1:0]  i_prdata,
    input  wire                             i_pready,
    input  wire                             i_in_valid,
    input  wire                             i_in_stall,
    input  wire [1:0]                       i_req_type,
    input  wire [7:0]                       i_dev_reg,
    input  wire [7:0]                       i_write_data,
    input  wire                             i_sda_in,
    input  wire                             i_out_valid,
    input  wire                             i_out_stall,
    input  wire                             i_scl_level,
    input  wire                             i_sda_level,
    input  wire                             i_sda_drive,
    input  wire                             i_busy_res,
    input  wire                             i_done_res,
    input  wire [7:0]                       i_read_result,
    output int                              o_fail_count,
    output int                              o_pending,
    output logic                            o_seq_busy,
    output int                              o_ticks,
    output int                              o_transfers,
    output int                              o_reads
);
    import sccb_pkg::*;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       drive;
        logic       busy;
        logic       done;
        logic [7:0] rdata;
    } t_lines;

    t_lines expected_lines[$];

    logic [7:0] tpu;
    logic [6:0] saddr;

    t_phase     ph;
    t_seg       seg;
    logic [3:0] nbits;
    logic [7:0] txs;
    logic [7:0] rxs;
    logic [11:0] dly;
    logic [7:0] hreg;
    logic [7:0] hdata;
    logic       rd;
    logic       scl;
    logic       sda;
    logic       drv;
    logic [7:0] last_rd;

    int fails = 0;
    int ticks = 0;
    int transfers = 0;
    int reads = 0;

    function automatic void reset_lines();
        tpu     = TICKS_PER_UNIT_RST;
        saddr   = SLAVE_ADDRESS_RST;
        ph      = P_IDLE;
        seg     = SEG_LEAD_STOP;
        nbits   = '0;
        txs     = '0;
        rxs     = '0;
        dly     = '0;
        hreg    = '0;
        hdata   = '0;
        rd      = 1'b0;
        scl     = 1'b1;
        sda     = 1'b1;
        drv     = 1'b1;
        last_rd = '0;
    endfunction

    function automatic void arm(input int units, input t_phase nxt);
        int t;
        t   = (tpu == 8'd0) ? 1 : int'(tpu);
        dly = 12'(units * t - 1);
        ph  = nxt;
    endfunction

    function automatic void load_byte(input logic [7:0] b);
        txs   = b;
        nbits = '0;
        drv   = 1'b1;
        sda   = b[7];
    endfunction

    function automatic void to_idle();
        ph  = P_IDLE;
        dly = '0;
    endfunction

    // one sequencer action once the running delay has expired
    function automatic logic sequence_action(input logic sdi);
        logic fin;
        fin = 1'b0;
        case (ph)
            P_STOP_A: begin
                scl = 1'b1;
                arm(U_5, P_STOP_B);
            end
            P_STOP_B: begin
                sda = 1'b0;
                drv = 1'b1;
                arm(U_5, P_STOP_C);
            end
            P_STOP_C: begin
                sda = 1'b1;
                if (seg == SEG_FINAL) begin
                    arm(U_3, P_DONE);
                end else if (seg == SEG_LEAD_STOP) begin
                    seg = SEG_ADDR_WR;
                    arm(rd ? U_8 : U_13, P_START_A);
                end else if (seg == SEG_DATA) begin
                    seg = SEG_ADDR_RD;
                    arm(U_8, P_START_A);
                end else begin
                    to_idle();
                end
            end
            P_DONE: begin
                if (rd) begin
                    last_rd = rxs;
                end
                to_idle();
                fin = 1'b1;
            end
            P_START_A: begin
                sda = 1'b1;
                scl = 1'b1;
                drv = 1'b1;
                arm(U_5, P_START_B);
            end
            P_START_B: begin
                sda = 1'b0;
                arm(U_5, P_START_C);
            end
            P_START_C: begin
                scl = 1'b0;
                if (seg == SEG_ADDR_WR) begin
                    load_byte({saddr, 1'b0});
                    arm(U_5, P_BIT_HI);
                end else if (seg == SEG_ADDR_RD) begin
                    load_byte({saddr, 1'b1});
                    arm(U_5, P_BIT_HI);
                end else begin
                    to_idle();
                end
            end
            P_BIT_HI: begin
                scl = 1'b1;
                arm(U_5, P_BIT_LO);
            end
            P_BIT_LO: begin
                scl   = 1'b0;
                txs   = {txs[6:0], 1'b0};
                nbits = nbits + 4'd1;
                if (nbits < BITS_PER_BYTE) begin
                    sda = txs[7];
                    arm(U_5, P_BIT_HI);
                end else begin
                    drv = 1'b0;
                    arm(U_3, P_ACK_HI);
                end
            end
            P_ACK_HI: begin
                scl = 1'b1;
                ph  = P_ACK_WAIT;
                dly = '0;
            end
            P_ACK_WAIT: begin
                if (!sdi) begin
                    arm(U_5, P_ACK_END);
                end
            end
            P_ACK_END: begin
                scl = 1'b0;
                drv = 1'b1;
                if (seg == SEG_ADDR_WR) begin
                    seg = SEG_REG;
                    load_byte(hreg);
                    arm(U_5, P_BIT_HI);
                end else if (seg == SEG_REG) begin
                    seg = SEG_DATA;
                    if (!rd) begin
                        load_byte(hdata);
                        arm(U_5, P_BIT_HI);
                    end else begin
                        arm(U_5, P_STOP_A);
                    end
                end else if (seg == SEG_DATA) begin
                    seg = SEG_FINAL;
                    arm(U_5, P_STOP_A);
                end else if (seg == SEG_ADDR_RD) begin
                    seg   = SEG_RX;
                    drv   = 1'b0;
                    rxs   = '0;
                    nbits = '0;
                    arm(U_5, P_RX_HI);
                end else begin
                    to_idle();
                end
            end
            P_RX_HI: begin
                scl = 1'b1;
                rxs = {rxs[6:0], sdi};
                arm(U_5, P_RX_LO);
            end
            P_RX_LO: begin
                scl   = 1'b0;
                nbits = nbits + 4'd1;
                if (nbits < BITS_PER_BYTE) begin
                    arm(U_5, P_RX_HI);
                end else begin
                    drv = 1'b1;
                    sda = 1'b1;
                    arm(U_5, P_NA_HI);
                end
            end
            P_NA_HI: begin
                scl = 1'b1;
                seg = SEG_FINAL;
                arm(U_10, P_STOP_A);
            end
            default: begin
                to_idle();
            end
        endcase
        return fin;
    endfunction

    function automatic t_lines next_lines(input logic [1:0] req, input logic [7:0] ra,
                                          input logic [7:0] wd, input logic sdi);
        t_lines r;
        logic   fin;
        fin = 1'b0;
        if (ph == P_IDLE) begin
            if (req == REQ_WRITE || req == REQ_READ) begin
                hreg  = ra;
                hdata = wd;
                rd    = (req == REQ_READ);
                seg   = SEG_LEAD_STOP;
                arm(U_5, P_STOP_A);
            end
        end else if (dly != '0) begin
            dly = dly - 12'd1;
        end else begin
            fin = sequence_action(sdi);
        end
        if (fin) begin
            transfers++;
            if (rd) begin
                reads++;
            end
        end
        r.scl   = scl;
        r.sda   = drv ? sda : 1'b0;
        r.drive = drv;
        r.busy  = (ph != P_IDLE);
        r.done  = fin;
        r.rdata = last_rd;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            if (fails < 10) begin
                $display("%t tick %0d: %s expected %0h, got %0h", $realtime, ticks, name,
                         want, got);
            end
            fails++;
        end
    endfunction

    initial begin
        reset_lines();
    end

    always @(posedge i_clk) begin : watch
        t_lines want;
        t_lines got;
        logic [31:0] reg_value;
        if (!i_rst_n) begin
            reset_lines();
            expected_lines.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_scl_level, i_sda_level, i_sda_drive, i_busy_res, i_done_res,
                       i_read_result};
                if (expected_lines.size() == 0) begin
                    if (fails < 10) begin
                        $display("%t unexpected result item %0h", $realtime, got);
                    end
                    fails++;
                end else begin
                    want = expected_lines.pop_front();
                    check_field("scl_level", want.scl, got.scl);
                    check_field("sda_level", want.sda, got.sda);
                    check_field("sda_drive", want.drive, got.drive);
                    check_field("busy_res", want.busy, got.busy);
                    check_field("done_res", want.done, got.done);
                    check_field("read_result", want.rdata, got.rdata);
                    ticks++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_lines.push_back(next_lines(i_req_type, i_dev_reg, i_write_data,
                                                    i_sda_in));
            end
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr[2] == REG_TICKS_PER_UNIT) begin
                        tpu = i_pwdata[7:0];
                    end else begin
                        saddr = i_pwdata[6:0];
                    end
                end else begin
                    reg_value = (i_paddr[2] == REG_TICKS_PER_UNIT) ? 32'(tpu) : 32'(saddr);
                    check_field("register readback", reg_value, i_prdata);
                end
            end
        end
        o_pending    = expected_lines.size();
        o_seq_busy   = (ph != P_IDLE);
        o_fail_count = fails;
        o_ticks      = ticks;
        o_transfers  = transfers;
        o_reads      = reads;
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// testbench top for the sccb master controller: tick stimulus, apb setup and verdict

module tb_top;
    import sccb_pkg::*;

    localparam logic [1:0] REQ_BAD = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    wire  [APB_DATA_W-1:0] prdata;
    wire                   pready;

    logic       in_valid = 1'b0;
    wire        in_stall;
    logic [1:0] req_type = REQ_TICK;
    logic [7:0] dev_reg = '0;
    logic [7:0] write_data = '0;
    logic       sda_in = 1'b1;

    wire        out_valid;
    logic       out_stall = 1'b0;
    wire        scl_level;
    wire        sda_level;
    wire        sda_drive;
    wire        busy_res;
    wire        done_res;
    wire  [7:0] read_result;

    int   fail_count;
    int   pending;
    logic seq_busy;
    int   ticks;
    int   transfers;
    int   reads;

    int tx_gap_max = 0;
    int rx_gap_max = 0;
    int hold_cycles = 0;
    int stuck_left = 0;
    int items_sent = 0;

    always #6 clk = ~clk;

    sccb_master_controller_core i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_req_type    (req_type),
        .i_dev_reg     (dev_reg),
        .i_write_data  (write_data),
        .i_sda_in      (sda_in),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_scl_level   (scl_level),
        .o_sda_level   (sda_level),
        .o_sda_drive   (sda_drive),
        .o_busy_res    (busy_res),
        .o_done_res    (done_res),
        .o_read_result (read_result)
    );

    sccb_tick_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_req_type    (req_type),
        .i_dev_reg     (dev_reg),
        .i_write_data  (write_data),
        .i_sda_in      (sda_in),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_scl_level   (scl_level),
        .i_sda_level   (sda_level),
        .i_sda_drive   (sda_drive),
        .i_busy_res    (busy_res),
        .i_done_res    (done_res),
        .i_read_result (read_result),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_seq_busy    (seq_busy),
        .o_ticks       (ticks),
        .o_transfers   (transfers),
        .o_reads       (reads)
    );

    // sda mostly random, now and then held high for a stretch to delay an ack
    function automatic logic next_sda();
        if (stuck_left > 0) begin
            stuck_left--;
            return 1'b1;
        end
        if ($urandom_range(0, 59) == 0) begin
            stuck_left = $urandom_range(20, 80);
        end
        return 1'($urandom);
    endfunction

    task automatic apb_access(input logic wr, input logic idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input logic [7:0] tpu, input logic [6:0] saddr);
        in_valid <= 1'b0;
        wait (pending == 0);
        apb_access(1'b1, REG_TICKS_PER_UNIT, ($urandom & 32'hFFFF_FF00) | 32'(tpu));
        apb_access(1'b1, REG_SLAVE_ADDRESS, ($urandom & 32'hFFFF_FF80) | 32'(saddr));
        apb_access(1'b0, REG_TICKS_PER_UNIT, '0);
        apb_access(1'b0, REG_SLAVE_ADDRESS, '0);
        @(negedge clk);
    endtask

    task automatic send_item(input logic [1:0] req, input logic [7:0] ra,
                             input logic [7:0] wd, input logic sdi);
        int gap;
        gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_type   <= req;
        dev_reg    <= ra;
        write_data <= wd;
        sda_in     <= sdi;
        in_valid   <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic tick();
        logic [1:0] req;
        req = REQ_TICK;
        if ($urandom_range(0, 99) < 3) begin
            case ($urandom_range(0, 2))
                0:       req = REQ_WRITE;
                1:       req = REQ_READ;
                default: req = REQ_BAD;
            endcase
        end
        send_item(req, 8'($urandom), 8'($urandom), next_sda());
    endtask

    task automatic finish_transfer();
        int guard;
        guard = 0;
        while (seq_busy && guard < 20000) begin
            tick();
            guard++;
        end
    endtask

    task automatic transfer(input logic [1:0] req, input logic [7:0] ra, input logic [7:0] wd);
        repeat ($urandom_range(0, 3)) begin
            send_item(($urandom_range(0, 1) == 0) ? REQ_TICK : REQ_BAD, 8'($urandom),
                      8'($urandom), 1'($urandom));
        end
        send_item(req, ra, wd, next_sda());
        finish_transfer();
    endtask

    initial begin : stimulus
        logic [7:0] tpu;
        logic first;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        apb_access(1'b0, REG_TICKS_PER_UNIT, '0);
        apb_access(1'b0, REG_SLAVE_ADDRESS, '0);

        transfer(REQ_WRITE, 8'hFF, 8'h00);
        configure(8'd0, 7'd127);
        transfer(REQ_READ, 8'h00, 8'hFF);

        // scale of two, then back to one while the transfer is still running
        configure(8'd2, 7'd0);
        tx_gap_max = 12;
        rx_gap_max = 12;
        send_item(REQ_WRITE, 8'h3C, 8'hC3, 1'b1);
        repeat (20) tick();
        configure(8'd1, 7'd85);
        finish_transfer();

        first = 1'b1;
        while (items_sent < 1500) begin
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 5))
                    0:       tpu = 8'd0;
                    1:       tpu = 8'd2;
                    2:       tpu = 8'd3;
                    default: tpu = 8'd1;
                endcase
                configure(tpu, 7'($urandom_range(0, 127)));
            end
            tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            if (first) begin
                tx_gap_max  = 0;
                hold_cycles = 250;
                first       = 1'b0;
            end
            transfer(($urandom_range(0, 1) == 0) ? REQ_WRITE : REQ_READ, 8'($urandom),
                     8'($urandom));
        end
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (10) @(posedge clk);
        $display("checked %0d tick items over %0d finished transfers, %0d of them reads",
                 ticks, transfers, reads);
        $display("scales 0 to 3 with a change mid transfer, random gaps and a long hold-off");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : result_side
        int gap;
        @(negedge clk);
        forever begin
            if (hold_cycles > 0) begin
                gap = hold_cycles;
                hold_cycles = 0;
            end else begin
                gap = (rx_gap_max > 0) ? $urandom_range(0, rx_gap_max) : 0;
            end
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
            @(negedge clk);
        end
    end

    initial begin : watchdog
        #(30_000_000);
        $display("timeout with %0d result items outstanding", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
sv/sccb_pkg.sv
sv/sccb_master_controller_core.sv
tb/sccb_tick_checker.sv
tb/tb_top.sv
